FILE: hw/rtl/tcw_pkg.sv
// Shared constants, types and codes of the text console writer.
package tcw_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = ROWS * COLUMNS;

  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int CHAR_W = 8;
  localparam int CELL_W = 16;
  localparam int ADDR_W = $clog2(CELLS);

  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
  localparam logic [CHAR_W-1:0] RESET_COLOR  = 8'h07;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  // Operands of the shared address unit: row * COLUMNS + col + base.
  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [ADDR_W-1:0] base;
  } addr_req_t;

endpackage

FILE: hw/rtl/tcw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/tcw_addr_unit.sv
// Shared linear address unit: row * COLUMNS + col + base.
module tcw_addr_unit (
  input  tcw_pkg::addr_req_t          req,
  output logic [tcw_pkg::ADDR_W-1:0]  addr
);
  import tcw_pkg::*;

  logic [ADDR_W+1:0] full;

  always_comb begin
    full = (ADDR_W+2)'(req.row) * (ADDR_W+2)'(COLUMNS)
         + (ADDR_W+2)'(req.col) + (ADDR_W+2)'(req.base);
    addr = full[ADDR_W-1:0];
  end

endmodule

FILE: hw/rtl/text_console_writer_core.sv
// Top level of the text console writer: sequencer, cursor, screen RAM and output register.
//
// Usage:
//   Commands enter on the s_axis channel, one transaction per command (put character,
//   write cell, read cell, no-op). Every command returns exactly one result transaction
//   on m_axis with the read cell value, the cursor after the command and a scroll flag.
//   The text color register is loaded through cfg_we / cfg_wdata; the user must do so
//   only while the block idles, which the block itself does not enforce.
// Sequencing:
//   s_axis_tready is high only while the sequencer idles, so one command is in flight
//   at a time. A command passes through the execute step, for a read a read-data step
//   behind the registered RAM port, and the finish step, which loads the result register.
//   A scroll walks the screen through the single RAM read port, one cell a cycle,
//   copying every row up by one and then blanking the last row.
// Reset:
//   rst clears the cursor, restores the reset color and starts a clearing pass that
//   writes a blank cell to every entry before tready rises.
// Stall:
//   A finished result sits in the output register until taken; the next command is
//   accepted meanwhile and waits in its finish step while the register is still full.
module text_console_writer_core (
  input  logic        clk,
  input  logic        rst,
  // fields from bit 0: opcode[1:0], ch[9:2], cell_color[17:10], col[24:18], row[29:25]
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  // fields from bit 0: cell_value[15:0], cursor_row[20:16], cursor_col[27:21], scrolled[28]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata
);
  import tcw_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_EXEC, ST_RDATA, ST_SCROLL, ST_BLANK, ST_FIN
  } state_t;

  localparam logic [ADDR_W-1:0] LAST_CELL   = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] COPY_CELLS  = ADDR_W'(CELLS - COLUMNS);

  state_t             state;
  logic [ADDR_W-1:0]  idx;
  logic               pend;
  logic [ADDR_W-1:0]  pend_addr;

  // latched command
  op_t                op_r;
  logic [CHAR_W-1:0]  ch_r;
  logic [CHAR_W-1:0]  color_r;
  logic [COL_W-1:0]   col_r;
  logic [ROW_W-1:0]   row_r;

  logic [ROW_W-1:0]   cur_row;
  logic [COL_W-1:0]   cur_col;
  logic [CHAR_W-1:0]  text_color;
  logic [CELL_W-1:0]  res_value;
  logic               res_scroll;

  // put-character decode
  logic               put_we;
  logic [ROW_W-1:0]   put_row;
  logic [COL_W-1:0]   put_col;
  logic [CELL_W-1:0]  put_data;
  logic [COL_W:0]     col_t;
  logic [ROW_W:0]     row_t;
  logic               need_scroll;
  logic               in_range;

  addr_req_t          req;
  logic [ADDR_W-1:0]  addr_sum;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [CELL_W-1:0]  ram_wdata;
  logic [CELL_W-1:0]  ram_rdata;

  assign s_axis_tready = (state == ST_IDLE);

  // Cursor motion and target cell of a put-character.
  always_comb begin
    put_we   = 1'b0;
    put_row  = cur_row;
    put_col  = cur_col;
    put_data = {text_color, ch_r};
    col_t    = {1'b0, cur_col};
    row_t    = {1'b0, cur_row};
    if (ch_r == CH_NEWLINE) begin
      col_t = '0;
      row_t = row_t + 1'b1;
    end else if (ch_r == CH_BACKSPACE) begin
      put_data = {text_color, CH_SPACE};
      if (cur_col != '0) begin
        col_t   = col_t - 1'b1;
        put_col = cur_col - 1'b1;
        put_we  = 1'b1;
      end else if (cur_row != '0) begin
        // wrap to the end of the previous row
        row_t   = row_t - 1'b1;
        col_t   = (COL_W+1)'(COLUMNS - 1);
        put_row = cur_row - 1'b1;
        put_col = COL_W'(COLUMNS - 1);
        put_we  = 1'b1;
      end
    end else begin
      put_we = 1'b1;
      col_t  = col_t + 1'b1;
    end
    if (col_t == (COL_W+1)'(COLUMNS)) begin
      col_t = '0;
      row_t = row_t + 1'b1;
    end
    need_scroll = (row_t == (ROW_W+1)'(ROWS));
  end

  assign in_range = ({1'b0, row_r} < (ROW_W+1)'(ROWS)) &&
                    ({1'b0, col_r} < (COL_W+1)'(COLUMNS));

  // Feed the shared address unit: source cell one row down while scrolling,
  // otherwise the cell the command touches.
  always_comb begin
    unique case (state)
      ST_SCROLL: begin
        // the last copy step only writes back; keep its read inside the screen
        if (idx < COPY_CELLS) begin
          req = '{row: ROW_W'(1), col: '0, base: idx};
        end else begin
          req = '{row: '0, col: '0, base: idx};
        end
      end
      default: begin
        if (op_r == OP_PUT) begin
          req = '{row: put_row, col: put_col, base: '0};
        end else begin
          req = '{row: row_r, col: col_r, base: '0};
        end
      end
    endcase
  end

  tcw_addr_unit u_addr (
    .req  (req),
    .addr (addr_sum)
  );

  // RAM write port selection.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_sum;
    ram_wdata = put_data;
    unique case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = idx;
        ram_wdata = {RESET_COLOR, CH_SPACE};
      end
      ST_EXEC: begin
        if (op_r == OP_PUT) begin
          ram_we = put_we;
        end else if (op_r == OP_WRITE) begin
          ram_we    = in_range;
          ram_wdata = {color_r, ch_r};
        end
      end
      ST_SCROLL: begin
        ram_we    = pend;
        ram_waddr = pend_addr;
        ram_wdata = ram_rdata;
      end
      ST_BLANK: begin
        ram_we    = 1'b1;
        ram_waddr = idx;
        ram_wdata = {text_color, CH_SPACE};
      end
      default: ;
    endcase
  end

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (addr_sum),
    .rdata (ram_rdata)
  );

  // Sequencer, cursor and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      idx           <= '0;
      pend          <= 1'b0;
      cur_row       <= '0;
      cur_col       <= '0;
      text_color    <= RESET_COLOR;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        text_color <= cfg_wdata;
      end
      // drop a taken result; the finish step reloads the register on its own
      if (m_axis_tvalid && m_axis_tready && (state != ST_FIN)) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          if (idx == LAST_CELL) begin
            idx   <= '0;
            state <= ST_IDLE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            op_r    <= op_t'(s_axis_tdata[1:0]);
            ch_r    <= s_axis_tdata[9:2];
            color_r <= s_axis_tdata[17:10];
            col_r   <= s_axis_tdata[24:18];
            row_r   <= s_axis_tdata[29:25];
            state   <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          res_value  <= '0;
          res_scroll <= 1'b0;
          unique case (op_r)
            OP_PUT: begin
              cur_col <= col_t[COL_W-1:0];
              if (need_scroll) begin
                cur_row    <= ROW_W'(ROWS - 1);
                res_scroll <= 1'b1;
                idx        <= '0;
                pend       <= 1'b0;
                state      <= ST_SCROLL;
              end else begin
                cur_row <= row_t[ROW_W-1:0];
                state   <= ST_FIN;
              end
            end
            OP_READ: state <= ST_RDATA;
            default: state <= ST_FIN;
          endcase
        end
        ST_RDATA: begin
          res_value <= in_range ? ram_rdata : '0;
          state     <= ST_FIN;
        end
        ST_SCROLL: begin
          // issue the read of the next row-down cell; write the previous one back
          if (idx < COPY_CELLS) begin
            pend      <= 1'b1;
            pend_addr <= idx;
            idx       <= idx + 1'b1;
          end else begin
            pend  <= 1'b0;
            state <= ST_BLANK;
          end
        end
        ST_BLANK: begin
          if (idx == LAST_CELL) begin
            state <= ST_FIN;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_FIN: begin
          // hold the result until the output register is free
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {3'b000, res_scroll, cur_col, cur_row, res_value};
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: hw/rtl/tcw_checker.sv
// Port-level checker of the text console writer and its bind to the top level.
module tcw_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);
  import tcw_pkg::*;

  // Reset starts the clearing pass: no result and no command taken.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> (!m_axis_tvalid && !s_axis_tready))
    else $error("result or ready right after reset");

  // One command in flight: ready drops after every accepted transaction.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second command accepted while one is in flight");

  // A scroll always leaves the cursor on the last row.
  a_scroll_row: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[28]) |-> (m_axis_tdata[20:16] == ROW_W'(ROWS - 1)))
    else $error("scroll result with cursor off the last row");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind text_console_writer_core tcw_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

FILE: dv/text_console_writer_core_test.sv
// Self-checking testbench of the text console writer: screen mirror, stimulus and checks.
`timescale 1ns / 1ps

module text_console_writer_core_test;
  import tcw_pkg::*;

  // Give up well past the slowest plausible run: the reset clearing pass, roughly 1550
  // commands plus sender gaps and receiver stalls, and a few dozen scrolls.
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int ERRORS_SHOWN = 100;
  localparam int PHASE_ITEMS = 254;

  typedef struct {
    op_t              op;
    logic [CHAR_W-1:0] ch;
    logic [7:0]        color;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
  } console_cmd_t;

  typedef struct {
    logic [CELL_W-1:0] cell_value;
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
    logic              scrolled;
  } console_reply_t;

  // Mirror of the screen, the cursor and the text color. Every accepted command updates
  // the mirror and queues the reply it must produce; replies are checked in order.
  class screen_mirror;
    logic [CELL_W-1:0] cells [CELLS];
    int                cur_r;
    int                cur_c;
    logic [7:0]        text_color;
    console_reply_t    pending [$];
    int                mismatches;

    function new();
      cur_r = 0;
      cur_c = 0;
      text_color = RESET_COLOR;
      mismatches = 0;
      foreach (cells[i]) cells[i] = {RESET_COLOR, CH_SPACE};
    endfunction

    function bit on_screen(int r, int c);
      return r < ROWS && c < COLUMNS;
    endfunction

    function bit put_char(logic [CHAR_W-1:0] ch);
      bit did_scroll;
      did_scroll = 1'b0;
      if (ch == CH_NEWLINE) begin
        cur_c = 0;
        cur_r++;
      end else if (ch == CH_BACKSPACE) begin
        // Step back, wrapping to the end of the previous row; do nothing at the origin.
        if (cur_c != 0) begin
          cur_c--;
          cells[cur_r * COLUMNS + cur_c] = {text_color, CH_SPACE};
        end else if (cur_r > 0) begin
          cur_r--;
          cur_c = COLUMNS - 1;
          cells[cur_r * COLUMNS + cur_c] = {text_color, CH_SPACE};
        end
      end else begin
        cells[cur_r * COLUMNS + cur_c] = {text_color, ch};
        cur_c++;
      end
      if (cur_c >= COLUMNS) begin
        cur_c = 0;
        cur_r++;
      end
      // Past the bottom: shift every row up by one and blank the last row.
      if (cur_r >= ROWS) begin
        for (int i = 0; i < CELLS - COLUMNS; i++) cells[i] = cells[i + COLUMNS];
        for (int i = CELLS - COLUMNS; i < CELLS; i++) cells[i] = {text_color, CH_SPACE};
        cur_r = ROWS - 1;
        did_scroll = 1'b1;
      end
      return did_scroll;
    endfunction

    function void take_command(console_cmd_t cmd);
      console_reply_t want;
      want.cell_value = '0;
      want.scrolled = 1'b0;
      case (cmd.op)
        OP_PUT: want.scrolled = put_char(cmd.ch);
        OP_WRITE: begin
          if (on_screen(int'(cmd.row), int'(cmd.col)))
            cells[cmd.row * COLUMNS + cmd.col] = {cmd.color, cmd.ch};
        end
        OP_READ: begin
          if (on_screen(int'(cmd.row), int'(cmd.col)))
            want.cell_value = cells[cmd.row * COLUMNS + cmd.col];
        end
        default: ;
      endcase
      want.cursor_row = cur_r[ROW_W-1:0];
      want.cursor_col = cur_c[COL_W-1:0];
      pending.push_back(want);
    endfunction

    function void flag(string field, int want, int got);
      mismatches++;
      if (mismatches <= ERRORS_SHOWN) $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
    endfunction

    function void check_reply(logic [31:0] data);
      console_reply_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= ERRORS_SHOWN) $error("result transaction 0x%08h with none expected", data);
        return;
      end
      want = pending.pop_front();
      if (data[15:0] !== want.cell_value)
        flag("cell_value", 32'(want.cell_value), 32'(data[15:0]));
      if (data[20:16] !== want.cursor_row)
        flag("cursor_row", 32'(want.cursor_row), 32'(data[20:16]));
      if (data[27:21] !== want.cursor_col)
        flag("cursor_col", 32'(want.cursor_col), 32'(data[27:21]));
      if (data[28] !== want.scrolled)
        flag("scrolled", 32'(want.scrolled), 32'(data[28]));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // fields from bit 0: opcode[1:0], ch[9:2], cell_color[17:10], col[24:18], row[29:25]
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // fields from bit 0: cell_value[15:0], cursor_row[20:16], cursor_col[27:21], scrolled[28]
  logic [31:0] m_axis_tdata;
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_wdata = '0;

  screen_mirror book;
  int          sent_items = 0;
  int          burst_left = 0;
  int          cycles = 0;
  int          rx_mode = 0;
  int          rx_left = 0;
  int          rx_tick = 0;

  text_console_writer_core DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Hard stop in case the block hangs or loses a result.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("text_console_writer_core_test: done, errors");
      $finish;
    end
  end

  // Receiver back-pressure: switch at random intervals between always ready,
  // coin-flip stalls, a fixed one-in-three pattern and long stalls.
  always @(posedge clk) begin
    rx_tick <= rx_tick + 1;
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(0, 3);
      rx_left <= $urandom_range(64, 512);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      2: m_axis_tready <= (rx_tick % 3 == 0);
      default: m_axis_tready <= ($urandom_range(0, 15) == 0);
    endcase
  end

  // Check every result transaction against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) book.check_reply(m_axis_tdata);
  end

  function automatic console_cmd_t make_cmd(op_t op, int ch, int color, int col, int row);
    console_cmd_t cmd;
    cmd.op = op;
    cmd.ch = CHAR_W'(ch);
    cmd.color = 8'(color);
    cmd.col = COL_W'(col);
    cmd.row = ROW_W'(row);
    return cmd;
  endfunction

  // Mostly on-screen positions; one in ten may fall anywhere in the field range.
  function automatic console_cmd_t place_cmd(op_t op, int ch, int color);
    if ($urandom_range(0, 9) == 0)
      return make_cmd(op, ch, color, $urandom_range(0, 127), $urandom_range(0, 31));
    return make_cmd(op, ch, color, $urandom_range(0, COLUMNS - 1), $urandom_range(0, ROWS - 1));
  endfunction

  function automatic console_cmd_t put_cmd(int ch);
    return make_cmd(OP_PUT, ch, $urandom_range(0, 255), $urandom_range(0, 127),
                    $urandom_range(0, 31));
  endfunction

  function automatic console_cmd_t random_cmd();
    int pick;
    int sel;
    pick = $urandom_range(0, 99);
    sel = $urandom_range(0, 99);
    if (pick < 55) begin
      if (sel < 8) return put_cmd(int'(CH_NEWLINE));
      if (sel < 20) return put_cmd(int'(CH_BACKSPACE));
      return put_cmd($urandom_range(0, 255));
    end
    if (pick < 73) return place_cmd(OP_WRITE, $urandom_range(0, 255), $urandom_range(0, 255));
    if (pick < 96) begin
      // Favor the cursor row, where printing and erasing just happened.
      if (sel < 40)
        return make_cmd(OP_READ, $urandom_range(0, 255), $urandom_range(0, 255),
                        $urandom_range(0, COLUMNS - 1), book.cur_r);
      return place_cmd(OP_READ, $urandom_range(0, 255), $urandom_range(0, 255));
    end
    return make_cmd(OP_NOP, $urandom_range(0, 255), $urandom_range(0, 255),
                    $urandom_range(0, 127), $urandom_range(0, 31));
  endfunction

  // Present one command and hold it until the handshake. Commands go out in bursts of
  // random length; between bursts drop tvalid for a random gap, sometimes for none.
  task automatic send_cmd(input console_cmd_t cmd);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {2'b00, cmd.row, cmd.col, cmd.color, cmd.ch, cmd.op};
    do @(posedge clk); while (!s_axis_tready);
    book.take_command(cmd);
    sent_items++;
  endtask

  // Drop tvalid and wait until every queued reply has come back.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (book.pending.size() != 0) @(posedge clk);
  endtask

  // Load the text color while nothing is in flight.
  task automatic load_color(input logic [7:0] color);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= color;
    @(posedge clk);
    cfg_we <= 1'b0;
    book.text_color = color;
  endtask

  task automatic run_phase(input int budget);
    int stop_at;
    int len;
    int r;
    int c;
    stop_at = sent_items + budget;
    while (sent_items < stop_at) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          len = $urandom_range(1, 20);
          repeat (len) send_cmd(random_cmd());
        end
        4, 5: begin
          // A line of text, ended by a newline half the time; long ones wrap.
          len = $urandom_range(1, 100);
          repeat (len) send_cmd(put_cmd($urandom_range(32, 126)));
          if ($urandom_range(0, 1)) send_cmd(put_cmd(int'(CH_NEWLINE)));
        end
        6: begin
          // Erase run, long enough at times to back over a row boundary.
          len = $urandom_range(1, 90);
          repeat (len) send_cmd(put_cmd(int'(CH_BACKSPACE)));
        end
        7: begin
          len = $urandom_range(1, 6);
          repeat (len) send_cmd(put_cmd(int'(CH_NEWLINE)));
        end
        8: begin
          len = $urandom_range(1, 8);
          repeat (len)
            send_cmd(make_cmd(OP_READ, $urandom_range(0, 255), $urandom_range(0, 255),
                              $urandom_range(0, COLUMNS - 1), book.cur_r));
        end
        default: begin
          // Write a cell, then read it back.
          r = $urandom_range(0, ROWS - 1);
          c = $urandom_range(0, COLUMNS - 1);
          send_cmd(make_cmd(OP_WRITE, $urandom_range(0, 255), $urandom_range(0, 255), c, r));
          send_cmd(make_cmd(OP_READ, $urandom_range(0, 255), $urandom_range(0, 255), c, r));
        end
      endcase
    end
  endtask

  initial begin
    book = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part under the reset color: screen corners after reset, extreme cells,
    // writes and reads off the screen, backspace at the origin, inside a row and across
    // a row boundary, printing in the last column, and the no-op code.
    send_cmd(make_cmd(OP_READ, 0, 0, 0, 0));
    send_cmd(make_cmd(OP_READ, 0, 0, COLUMNS - 1, ROWS - 1));
    send_cmd(make_cmd(OP_WRITE, 'hFF, 'hFF, 0, 0));
    send_cmd(make_cmd(OP_WRITE, 0, 0, COLUMNS - 1, ROWS - 1));
    send_cmd(make_cmd(OP_WRITE, 'h41, 'h1E, COLUMNS, 0));
    send_cmd(make_cmd(OP_WRITE, 'h42, 'h2D, 0, ROWS));
    send_cmd(make_cmd(OP_WRITE, 'hAA, 'h55, 127, 31));
    send_cmd(make_cmd(OP_READ, 0, 0, 0, 0));
    send_cmd(make_cmd(OP_READ, 0, 0, COLUMNS - 1, ROWS - 1));
    send_cmd(make_cmd(OP_READ, 0, 0, COLUMNS, 0));
    send_cmd(make_cmd(OP_READ, 'hFF, 'hFF, 127, 31));
    send_cmd(put_cmd(int'(CH_BACKSPACE)));
    send_cmd(put_cmd('h41));
    send_cmd(put_cmd(int'(CH_BACKSPACE)));
    send_cmd(put_cmd(int'(CH_NEWLINE)));
    send_cmd(put_cmd(int'(CH_BACKSPACE)));
    send_cmd(put_cmd('hFF));
    send_cmd(put_cmd(0));
    send_cmd(make_cmd(OP_NOP, 'hFF, 'hFF, 127, 31));
    send_cmd(make_cmd(OP_READ, 0, 0, COLUMNS - 1, 0));
    send_cmd(make_cmd(OP_READ, 0, 0, 0, 1));
    send_cmd(make_cmd(OP_WRITE, 'h55, 'hAA, 40, 12));
    send_cmd(make_cmd(OP_READ, 0, 0, 40, 12));
    send_cmd(make_cmd(OP_READ, 0, 0, 0, ROWS - 1));

    // Random part, one phase per text color; both extremes come first.
    load_color(8'hFF);
    run_phase(PHASE_ITEMS);
    load_color(8'h00);
    run_phase(PHASE_ITEMS);
    repeat (3) begin
      load_color(8'($urandom_range(0, 255)));
      run_phase(PHASE_ITEMS);
    end
    load_color(8'h1F);
    run_phase(PHASE_ITEMS);

    // Let any stray result show up before the verdict.
    drain();
    repeat (20) @(posedge clk);
    if (book.mismatches == 0) begin
      $display("text_console_writer_core_test: done, clean");
    end else begin
      $display("text_console_writer_core_test: done, errors");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_ram.sv
hw/rtl/tcw_addr_unit.sv
hw/rtl/text_console_writer_core.sv
hw/rtl/tcw_checker.sv
dv/text_console_writer_core_test.sv
